FILE: rtl/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LIN master frame sequencer.
// ----------------------------------------------------------------------------
package lmfs_pkg;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_START   = 3'd1,
		KIND_TX_DONE = 3'd2,
		KIND_RX_BYTE = 3'd3,
		KIND_READ    = 3'd4
	} kind_t;

	localparam logic [7:0] BREAK_BYTE = 8'h00;
	localparam logic [7:0] SYNC_BYTE  = 8'h55;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] index;
		logic [7:0] data;
		logic [7:0] pid;
		logic       slave_direction;
		logic [3:0] data_length;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       start_accepted;
		logic       busy_res;
		logic       response_ready;
		logic [7:0] read_byte;
	} result_t;

endpackage

FILE: rtl/lin_master_frame_sequencer.sv
// ----------------------------------------------------------------------------
// lin_master_frame_sequencer
// LIN master frame sequencing: break, sync, identifier, then master response
// bytes or collection of a slave response into the frame buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tuser kind, s_tdata item fields
//  m_axis    out  m_tvalid/m_tready  m_tdata result fields
//
//  One item per cycle sustained while m_tready takes each result; the result
//  reaches m_tdata via input register, then result register holding the buffer read.
//  Reset clears the frame state; the buffer holds nothing defined until written.
//  A stalled result holds the output; the input register still takes one item,
//  and further items wait on s_tready until m_tready frees the result register.
// ----------------------------------------------------------------------------
module lin_master_frame_sequencer
	import lmfs_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] index, [11:4] data, [19:12] pid, [20] slave_direction,
	// [24:21] data_length, [31:25] zero
	input  logic [31:0] s_tdata,
	// [2:0] kind
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] tx_valid, [8:1] tx_byte, [9] start_accepted, [10] busy_res,
	// [11] response_ready, [19:12] read_byte, [23:20] zero
	output logic [23:0] m_tdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    m_valid_q;
	logic    advance;
	result_t res;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind            <= s_tuser;
			item_s1.index           <= s_tdata[3:0];
			item_s1.data            <= s_tdata[11:4];
			item_s1.pid             <= s_tdata[19:12];
			item_s1.slave_direction <= s_tdata[20];
			item_s1.data_length     <= s_tdata[24:21];
		end
	end

	lmfs_seq #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.res   (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, res.read_byte, res.response_ready, res.busy_res,
		res.start_accepted, res.tx_byte, res.tx_valid};

endmodule

FILE: rtl/lmfs_seq.sv
// ----------------------------------------------------------------------------
// lmfs_seq
// Frame state machine and response buffer; one item per step, result
// registered at the step edge.
// ----------------------------------------------------------------------------
module lmfs_seq
	import lmfs_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res
);

	localparam int DEPTH = MAX_DATA_BYTES + 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [3:0] LEN_MAX = 4'(MAX_DATA_BYTES);
	localparam logic [3:0] DEPTH_W = 4'(DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BREAK,
		PH_SYNC,
		PH_IDENT,
		PH_TX_RESP,
		PH_RX_RESP
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_BUSY,
		ST_RECEIVED
	} status_t;

	phase_t     phase_q, phase_d;
	status_t    status_q, status_d;
	logic [3:0] pos_q, pos_d;
	logic [7:0] ident_q, ident_d;
	logic       slave_q, slave_d;
	logic [3:0] len_q, len_d;

	logic [7:0] buf_mem [DEPTH];

	logic       tx_v, tx_mem, accepted, rd_en;
	logic [7:0] tx_const;
	logic [3:0] raddr, waddr, pos_after;
	logic       we, rin;
	logic [7:0] wdata;

	result_t res_q;

	always_comb begin
		phase_d   = phase_q;
		status_d  = status_q;
		pos_d     = pos_q;
		ident_d   = ident_q;
		slave_d   = slave_q;
		len_d     = len_q;
		tx_v      = 1'b0;
		tx_mem    = 1'b0;
		tx_const  = BREAK_BYTE;
		accepted  = 1'b0;
		rd_en     = 1'b0;
		raddr     = pos_q;
		we        = 1'b0;
		waddr     = item.index;
		wdata     = item.data;
		pos_after = pos_q;
		case (item.kind)
			KIND_WRITE: begin
				we = (item.index < DEPTH_W);
			end
			KIND_START: begin
				if (phase_q == PH_IDLE) begin
					ident_d  = item.pid;
					slave_d  = item.slave_direction;
					len_d    = (item.data_length > LEN_MAX) ? LEN_MAX : item.data_length;
					pos_d    = 4'd0;
					tx_v     = 1'b1;
					tx_const = BREAK_BYTE;
					phase_d  = PH_BREAK;
					accepted = 1'b1;
				end
			end
			KIND_TX_DONE: begin
				unique case (phase_q)
					PH_BREAK: begin
						tx_v     = 1'b1;
						tx_const = SYNC_BYTE;
						phase_d  = PH_SYNC;
					end
					PH_SYNC: begin
						tx_v     = 1'b1;
						tx_const = ident_q;
						phase_d  = PH_IDENT;
					end
					PH_IDENT: begin
						if (!slave_q) begin
							tx_v    = 1'b1;
							tx_mem  = 1'b1;
							raddr   = 4'd0;
							pos_d   = 4'd1;
							phase_d = PH_TX_RESP;
						end else begin
							pos_d    = 4'd0;
							phase_d  = PH_RX_RESP;
							status_d = ST_BUSY;
						end
					end
					PH_TX_RESP: begin
						if (pos_q <= len_q) begin
							tx_v      = 1'b1;
							tx_mem    = 1'b1;
							pos_after = pos_q + 4'd1;
						end
						pos_d = pos_after;
						if (pos_after > len_q) begin
							phase_d = PH_IDLE;
							pos_d   = 4'd0;
						end
					end
					default: ;
				endcase
			end
			KIND_RX_BYTE: begin
				if (phase_q == PH_RX_RESP) begin
					if (pos_q <= len_q && pos_q < DEPTH_W) begin
						we        = 1'b1;
						waddr     = pos_q;
						pos_after = pos_q + 4'd1;
					end
					pos_d = pos_after;
					if (pos_after > len_q) begin
						phase_d  = PH_IDLE;
						status_d = ST_RECEIVED;
						pos_d    = 4'd0;
					end
				end
			end
			KIND_READ: begin
				rd_en = 1'b1;
				raddr = item.index;
			end
			default: ;
		endcase
		rin = (raddr < DEPTH_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			status_q <= ST_NONE;
			pos_q    <= 4'd0;
			ident_q  <= 8'd0;
			slave_q  <= 1'b0;
			len_q    <= 4'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			status_q <= status_d;
			pos_q    <= pos_d;
			ident_q  <= ident_d;
			slave_q  <= slave_d;
			len_q    <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && we) begin
			buf_mem[waddr[AW-1:0]] <= wdata;
		end
	end

	// result register; buffer read is taken here
	always_ff @(posedge clk) begin
		if (step) begin
			res_q.tx_valid       <= tx_v;
			res_q.start_accepted <= accepted;
			res_q.busy_res       <= (phase_d != PH_IDLE);
			res_q.response_ready <= (phase_d == PH_IDLE) && slave_d &&
				(status_d == ST_RECEIVED);
			if (!tx_v) begin
				res_q.tx_byte <= 8'd0;
			end else if (tx_mem) begin
				res_q.tx_byte <= rin ? buf_mem[raddr[AW-1:0]] : 8'd0;
			end else begin
				res_q.tx_byte <= tx_const;
			end
			if (rd_en && rin) begin
				res_q.read_byte <= buf_mem[raddr[AW-1:0]];
			end else begin
				res_q.read_byte <= 8'd0;
			end
		end
	end

	assign res = res_q;

	a_start_busy_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.kind == KIND_START && phase_q != PH_IDLE |=> !res_q.start_accepted)
		else $error("start accepted while busy");

	a_start_break: assert property (@(posedge clk) disable iff (!arst_n)
		step && accepted |=> res_q.tx_valid && res_q.tx_byte == BREAK_BYTE && res_q.busy_res)
		else $error("accepted start without break byte");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step ##1 res_q.response_ready |-> phase_q == PH_IDLE && status_q == ST_RECEIVED)
		else $error("response ready while frame in progress");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= DEPTH_W && len_q <= LEN_MAX)
		else $error("byte position or length out of range");

endmodule
